// ===== rtl/touch_tap_swipe_classifier_top_macros.svh =====
// Assertion macros shared by the touch classifier RTL.
`ifndef TOUCH_TAP_SWIPE_CLASSIFIER_TOP_MACROS_SVH
`define TOUCH_TAP_SWIPE_CLASSIFIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and disabled during reset.
`define TTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("touch classifier check failed");
// Next-cycle implication, checked on clk and disabled during reset.
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch classifier check failed");
`else
`define TTS_ASSERT_IMPL(label, ante, cons)
`define TTS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/tts_pkg.sv =====
// Shared types and constants of the touch tap and swipe classifier.
package tts_pkg;

  // Default panel geometry and finger limit.
  localparam int DEF_PANEL_WIDTH  = 368;
  localparam int DEF_PANEL_HEIGHT = 448;
  localparam int DEF_MAX_FINGERS  = 2;

  // Frame field widths.
  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 12;
  localparam int COUNT_W = 4;

  // Configuration port.
  localparam int THR_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd42;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED   = 3'd0,
    CFG_SWAP_AXES = 3'd1,
    CFG_MIRROR_X  = 3'd2,
    CFG_MIRROR_Y  = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_idx_t;

  // Gesture codes of a result item.
  localparam int GESTURE_W = 3;
  typedef enum logic [GESTURE_W-1:0] {
    G_NONE  = 3'd0,
    G_TAP   = 3'd1,
    G_LEFT  = 3'd2,
    G_RIGHT = 3'd3,
    G_UP    = 3'd4,
    G_DOWN  = 3'd5
  } gesture_t;

endpackage

// ===== rtl/tts_if.sv =====
// Handshake channel interfaces of the touch tap and swipe classifier.

// Input channel: one poll of the controller's data frame per item.
interface tts_in_if;
  import tts_pkg::*;
  logic              valid;
  logic              ready;
  logic              frame_ok;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] x_high;
  logic [BYTE_W-1:0] x_low;
  logic [BYTE_W-1:0] y_high;
  logic [BYTE_W-1:0] y_low;
  modport source (output valid, frame_ok, status_byte, x_high, x_low, y_high, y_low,
                  input ready);
  modport sink (input valid, frame_ok, status_byte, x_high, x_low, y_high, y_low,
                output ready);
endinterface

// Result channel: one classification per item.
interface tts_out_if #(
  parameter int XW = 9,
  parameter int YW = 9
);
  import tts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [GESTURE_W-1:0] gesture;
  logic [XW-1:0]        event_x;
  logic [YW-1:0]        event_y;
  logic                 pressed;
  modport source (output valid, gesture, event_x, event_y, pressed, input ready);
  modport sink (input valid, gesture, event_x, event_y, pressed, output ready);
endinterface

// Configuration write channel.
interface tts_cfg_if;
  import tts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/touch_tap_swipe_classifier_top.sv =====
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the receiver is ready; the result register frees as its item is taken.
// The press tracking state updates as an item moves from the input to the result register.
// Reset (rst_n low, synchronous) empties both registers, ends any touch and restores
// the configuration defaults. Configuration writes are always ready.
// Top level of the touch tap and swipe classifier.
`include "touch_tap_swipe_classifier_top_macros.svh"

module touch_tap_swipe_classifier_top #(
  parameter int PANEL_WIDTH  = tts_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = tts_pkg::DEF_PANEL_HEIGHT,
  parameter int MAX_FINGERS  = tts_pkg::DEF_MAX_FINGERS
) (
  input  logic        clk,
  input  logic        rst_n,
  tts_in_if.sink      in_ch,
  tts_out_if.source   out_ch,
  tts_cfg_if.sink     cfg_ch
);
  import tts_pkg::*;

  localparam int XW = $clog2(PANEL_WIDTH);
  localparam int YW = $clog2(PANEL_HEIGHT);
  localparam int CXW = (XW > THR_W) ? XW : THR_W;
  localparam int CYW = (YW > THR_W) ? YW : THR_W;
  localparam int DW  = (XW > YW) ? XW : YW;
  localparam logic [RAW_W-1:0] RAW_XMAX = RAW_W'(PANEL_WIDTH - 1);
  localparam logic [RAW_W-1:0] RAW_YMAX = RAW_W'(PANEL_HEIGHT - 1);
  localparam logic [XW-1:0] XMAX = XW'(PANEL_WIDTH - 1);
  localparam logic [YW-1:0] YMAX = YW'(PANEL_HEIGHT - 1);
  localparam logic [COUNT_W-1:0] FINGER_MAX = COUNT_W'(MAX_FINGERS);

  // Configuration registers.
  logic             enabled_r;
  logic             swap_axes_r;
  logic             mirror_x_r;
  logic             mirror_y_r;
  logic [THR_W-1:0] threshold_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      swap_axes_r <= 1'b0;
      mirror_x_r  <= 1'b0;
      mirror_y_r  <= 1'b0;
      threshold_r <= THR_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ENABLED:   enabled_r   <= cfg_ch.data[0];
        CFG_SWAP_AXES: swap_axes_r <= cfg_ch.data[0];
        CFG_MIRROR_X:  mirror_x_r  <= cfg_ch.data[0];
        CFG_MIRROR_Y:  mirror_y_r  <= cfg_ch.data[0];
        CFG_THRESHOLD: threshold_r <= cfg_ch.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and its hand-off to the result register.
  logic              s1_valid_r;
  logic              s1_frame_ok_r;
  logic [BYTE_W-1:0] s1_status_r;
  logic [BYTE_W-1:0] s1_x_high_r;
  logic [BYTE_W-1:0] s1_x_low_r;
  logic [BYTE_W-1:0] s1_y_high_r;
  logic [BYTE_W-1:0] s1_y_low_r;
  logic              s1_adv;
  logic              out_valid_r;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_frame_ok_r <= in_ch.frame_ok;
      s1_status_r   <= in_ch.status_byte;
      s1_x_high_r   <= in_ch.x_high;
      s1_x_low_r    <= in_ch.x_low;
      s1_y_high_r   <= in_ch.y_high;
      s1_y_low_r    <= in_ch.y_low;
    end
  end

  // Touch tracking state.
  logic          touch_active_r, touch_active_nxt;
  logic [XW-1:0] start_x_r, start_x_nxt;
  logic [YW-1:0] start_y_r, start_y_nxt;
  logic [XW-1:0] last_x_r, last_x_nxt;
  logic [YW-1:0] last_y_r, last_y_nxt;

  // Press detection and coordinate mapping.
  logic [COUNT_W-1:0] fingers;
  logic               press;
  logic [RAW_W-1:0]   raw_x, raw_y, sw_x, sw_y;
  logic [XW-1:0]      clip_x, map_x;
  logic [YW-1:0]      clip_y, map_y;

  always_comb begin
    fingers = s1_status_r[COUNT_W-1:0];
    press   = enabled_r && s1_frame_ok_r && (fingers != '0) && (fingers <= FINGER_MAX);
    raw_x   = {s1_x_high_r[COUNT_W-1:0], s1_x_low_r};
    raw_y   = {s1_y_high_r[COUNT_W-1:0], s1_y_low_r};
    sw_x    = swap_axes_r ? raw_y : raw_x;
    sw_y    = swap_axes_r ? raw_x : raw_y;
    clip_x  = (sw_x > RAW_XMAX) ? XMAX : sw_x[XW-1:0];
    clip_y  = (sw_y > RAW_YMAX) ? YMAX : sw_y[YW-1:0];
    map_x   = mirror_x_r ? (XMAX - clip_x) : clip_x;
    map_y   = mirror_y_r ? (YMAX - clip_y) : clip_y;
  end

  // Release classification from the start and last points.
  logic [XW-1:0] adx;
  logic [YW-1:0] ady;
  logic          is_tap;
  logic          x_dominant;
  gesture_t      swipe_dir;

  always_comb begin
    adx = (last_x_r >= start_x_r) ? (last_x_r - start_x_r) : (start_x_r - last_x_r);
    ady = (last_y_r >= start_y_r) ? (last_y_r - start_y_r) : (start_y_r - last_y_r);
    is_tap = (CXW'(adx) < CXW'(threshold_r)) && (CYW'(ady) < CYW'(threshold_r));
    x_dominant = DW'(adx) > DW'(ady);
    if (x_dominant) begin
      swipe_dir = (last_x_r > start_x_r) ? G_RIGHT : G_LEFT;
    end else begin
      swipe_dir = (last_y_r > start_y_r) ? G_DOWN : G_UP;
    end
  end

  // Result and next state of the item in the input register.
  gesture_t      gesture_nxt;
  logic [XW-1:0] event_x_nxt;
  logic [YW-1:0] event_y_nxt;

  always_comb begin
    touch_active_nxt = touch_active_r;
    start_x_nxt      = start_x_r;
    start_y_nxt      = start_y_r;
    last_x_nxt       = last_x_r;
    last_y_nxt       = last_y_r;
    gesture_nxt      = G_NONE;
    event_x_nxt      = '0;
    event_y_nxt      = '0;
    priority if (press) begin
      touch_active_nxt = 1'b1;
      if (!touch_active_r) begin
        start_x_nxt = map_x;
        start_y_nxt = map_y;
      end
      last_x_nxt = map_x;
      last_y_nxt = map_y;
    end else if (touch_active_r) begin
      touch_active_nxt = 1'b0;
      if (is_tap) begin
        gesture_nxt = G_TAP;
        event_x_nxt = start_x_r;
        event_y_nxt = start_y_r;
      end else begin
        gesture_nxt = swipe_dir;
        event_x_nxt = last_x_r;
        event_y_nxt = last_y_r;
      end
    end else begin
      // No press and no touch in progress: the defaults stand.
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_active_r <= 1'b0;
      start_x_r      <= '0;
      start_y_r      <= '0;
      last_x_r       <= '0;
      last_y_r       <= '0;
    end else if (s1_adv) begin
      touch_active_r <= touch_active_nxt;
      start_x_r      <= start_x_nxt;
      start_y_r      <= start_y_nxt;
      last_x_r       <= last_x_nxt;
      last_y_r       <= last_y_nxt;
    end
  end

  // Result register.
  gesture_t      out_gesture_r;
  logic [XW-1:0] out_event_x_r;
  logic [YW-1:0] out_event_y_r;
  logic          out_pressed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_gesture_r <= gesture_nxt;
      out_event_x_r <= event_x_nxt;
      out_event_y_r <= event_y_nxt;
      out_pressed_r <= press;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.gesture = out_gesture_r;
  assign out_ch.event_x = out_event_x_r;
  assign out_ch.event_y = out_event_y_r;
  assign out_ch.pressed = out_pressed_r;

  // A gesture is only reported on a poll that is not a press.
  `TTS_ASSERT_IMPL(a_gesture_not_pressed, out_valid_r && (out_gesture_r != G_NONE), !out_pressed_r)
  // A result with no gesture carries a zero position.
  `TTS_ASSERT_IMPL(a_none_zero_pos, out_valid_r && (out_gesture_r == G_NONE), (out_event_x_r == '0) && (out_event_y_r == '0))
  // A press that moves on leaves a touch in progress.
  `TTS_ASSERT_NEXT(a_press_starts_touch, s1_adv && press, touch_active_r)
  // A reported gesture ends the touch.
  `TTS_ASSERT_NEXT(a_gesture_ends_touch, s1_adv && (gesture_nxt != G_NONE), !touch_active_r && out_valid_r)
  // Tracked points stay on the panel.
  `TTS_ASSERT_IMPL(a_points_on_panel, touch_active_r, (last_x_r <= XMAX) && (start_x_r <= XMAX) && (last_y_r <= YMAX) && (start_y_r <= YMAX))

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the touch tap and swipe classifier.
`timescale 1ns / 100ps

module tb;
  import tts_pkg::*;

  localparam int PANEL_W = DEF_PANEL_WIDTH;
  localparam int PANEL_H = DEF_PANEL_HEIGHT;
  localparam int MAX_FINGERS = DEF_MAX_FINGERS;
  localparam int COORD_W = 9;
  localparam int RAW_MAX = (1 << RAW_W) - 1;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int CFG_IDX_TOP = (1 << CFG_IDX_W) - 1;
  localparam logic [THR_W-1:0] THR_MAX = '1;
  localparam int RANDOM_POLLS = 340;

  // One poll of the controller frame and one classification.
  typedef struct packed {
    logic              frame_ok;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] x_high;
    logic [BYTE_W-1:0] x_low;
    logic [BYTE_W-1:0] y_high;
    logic [BYTE_W-1:0] y_low;
  } poll_t;

  typedef struct packed {
    gesture_t           gesture;
    logic [COORD_W-1:0] event_x;
    logic [COORD_W-1:0] event_y;
    logic               pressed;
  } gesture_result_t;

  // Ways a poll can end a touch.
  typedef enum {REL_NO_FRAME, REL_NO_FINGER, REL_TOO_MANY} release_kind_t;

  // Receiver stall patterns.
  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst_n;

  tts_in_if in_ch();
  tts_out_if #(.XW(COORD_W), .YW(COORD_W)) out_ch();
  tts_cfg_if cfg_ch();

  touch_tap_swipe_classifier_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted configuration and touch tracking state.
  bit               cfg_enabled;
  bit               cfg_swap;
  bit               cfg_mirror_x;
  bit               cfg_mirror_y;
  logic [THR_W-1:0] cfg_threshold;
  bit               touch_on;
  int               start_x;
  int               start_y;
  int               last_x;
  int               last_y;

  gesture_result_t  pending_gestures[$];

  int  err_count;
  int  polls_sent;
  int  cfg_writes;
  int  n_results;
  int  n_taps;
  int  n_swipes;
  int  n_idle;
  int  burst_left;
  bit  use_gaps;
  int  hold_req;

  always #5 clk = ~clk;

  // Works out the classification of one poll and advances the touch state.
  function automatic gesture_result_t classify_poll(input poll_t p);
    gesture_result_t r;
    int fingers;
    int a;
    int b;
    int t;
    int adx;
    int ady;
    int thr;
    bit press;
    r = '0;
    r.gesture = G_NONE;
    thr = int'(cfg_threshold);
    fingers = int'(p.status_byte[COUNT_W-1:0]);
    press = cfg_enabled && p.frame_ok && fingers >= 1 && fingers <= MAX_FINGERS;
    if (press) begin
      a = int'({p.x_high[3:0], p.x_low});
      b = int'({p.y_high[3:0], p.y_low});
      if (cfg_swap) begin
        t = a;
        a = b;
        b = t;
      end
      if (a > PANEL_W - 1) a = PANEL_W - 1;
      if (b > PANEL_H - 1) b = PANEL_H - 1;
      if (cfg_mirror_x) a = PANEL_W - 1 - a;
      if (cfg_mirror_y) b = PANEL_H - 1 - b;
      if (!touch_on) begin
        touch_on = 1'b1;
        start_x = a;
        start_y = b;
      end
      last_x = a;
      last_y = b;
    end else if (touch_on) begin
      adx = (last_x > start_x) ? last_x - start_x : start_x - last_x;
      ady = (last_y > start_y) ? last_y - start_y : start_y - last_y;
      touch_on = 1'b0;
      if (adx < thr && ady < thr) begin
        r.gesture = G_TAP;
        r.event_x = COORD_W'(start_x);
        r.event_y = COORD_W'(start_y);
      end else begin
        r.event_x = COORD_W'(last_x);
        r.event_y = COORD_W'(last_y);
        if (adx > ady) r.gesture = (last_x > start_x) ? G_RIGHT : G_LEFT;
        else r.gesture = (last_y > start_y) ? G_DOWN : G_UP;
      end
    end
    r.pressed = press;
    return r;
  endfunction

  // Monitor: follows configuration writes, predicts each accepted item and
  // checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    poll_t seen;
    gesture_result_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cfg_writes++;
        case (cfg_ch.index)
          CFG_ENABLED:   cfg_enabled = cfg_ch.data[0];
          CFG_SWAP_AXES: cfg_swap = cfg_ch.data[0];
          CFG_MIRROR_X:  cfg_mirror_x = cfg_ch.data[0];
          CFG_MIRROR_Y:  cfg_mirror_y = cfg_ch.data[0];
          CFG_THRESHOLD: cfg_threshold = cfg_ch.data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.frame_ok = in_ch.frame_ok;
        seen.status_byte = in_ch.status_byte;
        seen.x_high = in_ch.x_high;
        seen.x_low = in_ch.x_low;
        seen.y_high = in_ch.y_high;
        seen.y_low = in_ch.y_low;
        pending_gestures.push_back(classify_poll(seen));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_gestures.size() == 0) begin
          $error("result item with no item pending: gesture %0d", out_ch.gesture);
          err_count++;
        end else begin
          want = pending_gestures.pop_front();
          n_results++;
          if (want.gesture == G_TAP) n_taps++;
          else if (want.gesture == G_NONE) n_idle++;
          else n_swipes++;
          if (out_ch.gesture !== want.gesture) begin
            $error("gesture: expected %0d, actual %0d", want.gesture, out_ch.gesture);
            err_count++;
          end
          if (out_ch.event_x !== want.event_x) begin
            $error("event_x: expected %0d, actual %0d", want.event_x, out_ch.event_x);
            err_count++;
          end
          if (out_ch.event_y !== want.event_y) begin
            $error("event_y: expected %0d, actual %0d", want.event_y, out_ch.event_y);
            err_count++;
          end
          if (out_ch.pressed !== want.pressed) begin
            $error("pressed: expected %0d, actual %0d", want.pressed, out_ch.pressed);
            err_count++;
          end
        end
      end
    end
  end

  // Receiver: changes its stall pattern after each run of random length and holds off
  // completely when a test asks for it.
  initial begin : receiver
    rx_mode_t mode;
    int seg;
    int phase;
    int hold;
    mode = RX_FREE;
    seg = 0;
    phase = 0;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (seg == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        seg = $urandom_range(8, 64);
      end
      seg--;
      phase++;
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  // Sends one poll, opening a random gap between bursts.
  task automatic send_poll(input poll_t p);
    if (burst_left == 0) begin
      if (use_gaps) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.frame_ok <= p.frame_ok;
    in_ch.status_byte <= p.status_byte;
    in_ch.x_high <= p.x_high;
    in_ch.x_low <= p.x_low;
    in_ch.y_high <= p.y_high;
    in_ch.y_low <= p.y_low;
    do @(posedge clk); while (!in_ch.ready);
    polls_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_gestures.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Writes all registers while the block is idle. The unused upper bits of the
  // flag registers and a write to an unused index carry random data.
  task automatic write_config(input bit en, input bit swap, input bit mx, input bit my,
                              input logic [THR_W-1:0] thr);
    wait_drain();
    put_reg(CFG_ENABLED, {(CFG_DATA_W-1)'($urandom), en});
    put_reg(CFG_SWAP_AXES, {(CFG_DATA_W-1)'($urandom), swap});
    put_reg(CFG_MIRROR_X, {(CFG_DATA_W-1)'($urandom), mx});
    put_reg(CFG_MIRROR_Y, {(CFG_DATA_W-1)'($urandom), my});
    put_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    put_reg(CFG_IDX_W'($urandom_range(CFG_THRESHOLD + 1, CFG_IDX_TOP)), CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // A press at raw coordinates; the ignored upper nibbles are random.
  function automatic poll_t press_poll(input int x, input int y, input int fingers);
    poll_t p;
    p.frame_ok = 1'b1;
    p.status_byte = {4'($urandom), 4'(fingers)};
    p.x_high = {4'($urandom), 4'(x >> 8)};
    p.x_low = 8'(x);
    p.y_high = {4'($urandom), 4'(y >> 8)};
    p.y_low = 8'(y);
    return p;
  endfunction

  // A poll that is not a press, with random content elsewhere.
  function automatic poll_t release_poll(input release_kind_t kind);
    poll_t p;
    p.frame_ok = 1'b1;
    p.status_byte = 8'($urandom);
    p.x_high = 8'($urandom);
    p.x_low = 8'($urandom);
    p.y_high = 8'($urandom);
    p.y_low = 8'($urandom);
    case (kind)
      REL_NO_FRAME:  p.frame_ok = 1'b0;
      REL_NO_FINGER: p.status_byte[COUNT_W-1:0] = '0;
      default:       p.status_byte[COUNT_W-1:0] = COUNT_W'($urandom_range(MAX_FINGERS + 1, COUNT_MAX));
    endcase
    return p;
  endfunction

  function automatic poll_t noise_poll();
    poll_t p;
    p.frame_ok = 1'($urandom);
    p.status_byte = 8'($urandom);
    p.x_high = 8'($urandom);
    p.x_low = 8'($urandom);
    p.y_high = 8'($urandom);
    p.y_low = 8'($urandom);
    return p;
  endfunction

  // Raw coordinate moved by a random amount, kept within 12 bits.
  function automatic int jitter(input int base, input int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v;
  endfunction

  // One touch: a few presses around a start point, then a release.
  task automatic send_touch();
    int n;
    int spread;
    int sx;
    int sy;
    n = $urandom_range(1, 8);
    spread = ($urandom_range(0, 2) == 0) ? 700 : 40;
    if ($urandom_range(0, 4) == 0) begin
      sx = $urandom_range(0, RAW_MAX);
      sy = $urandom_range(0, RAW_MAX);
    end else begin
      sx = $urandom_range(0, PANEL_W + 40);
      sy = $urandom_range(0, PANEL_H + 40);
    end
    send_poll(press_poll(sx, sy, $urandom_range(1, MAX_FINGERS)));
    for (int i = 1; i < n; i++) begin
      send_poll(press_poll(jitter(sx, spread), jitter(sy, spread), $urandom_range(1, MAX_FINGERS)));
    end
    send_poll(release_poll(release_kind_t'($urandom_range(0, 2))));
  endtask

  // Taps, every swipe direction, clipping, ties and stray releases.
  task automatic test_directed();
    // Disabled after reset, so a press is not seen.
    send_poll(press_poll(100, 100, 1));
    write_config(1'b1, 1'b0, 1'b0, 1'b0, THR_RESET);
    // Small move gives a tap at the start point.
    send_poll(press_poll(100, 100, 1));
    send_poll(press_poll(110, 120, MAX_FINGERS));
    send_poll(release_poll(REL_NO_FRAME));
    // Long horizontal move to the right.
    send_poll(press_poll(10, 200, 1));
    send_poll(press_poll(300, 210, MAX_FINGERS));
    send_poll(release_poll(REL_NO_FINGER));
    // Coordinates beyond the panel are clipped; then a move to the left.
    send_poll(press_poll(RAW_MAX, RAW_MAX, 1));
    send_poll(press_poll(0, RAW_MAX, 1));
    send_poll(release_poll(REL_TOO_MANY));
    // Equal deltas go to the vertical axis.
    send_poll(press_poll(100, 100, 1));
    send_poll(press_poll(150, 150, 1));
    send_poll(release_poll(REL_NO_FRAME));
    // Upward move.
    send_poll(press_poll(200, 400, 1));
    send_poll(press_poll(210, 0, 1));
    send_poll(release_poll(REL_TOO_MANY));
    // Release with no touch in progress.
    send_poll(release_poll(REL_NO_FINGER));
  endtask

  // Register extremes: all mappings on with a zero threshold, then the
  // largest threshold, where every touch is a tap.
  task automatic test_config_extremes();
    write_config(1'b1, 1'b1, 1'b1, 1'b1, '0);
    send_poll(press_poll(50, 60, 1));
    send_poll(release_poll(REL_NO_FRAME));
    write_config(1'b1, 1'b0, 1'b0, 1'b0, THR_MAX);
    send_poll(press_poll(0, 0, 1));
    send_poll(press_poll(RAW_MAX, RAW_MAX, MAX_FINGERS));
    send_poll(release_poll(REL_NO_FINGER));
  endtask

  // Mostly well-formed touches with random content, some noise, and a new
  // random configuration every few dozen items.
  task automatic test_random();
    int goal;
    int since_cfg;
    int sent_before;
    logic [THR_W-1:0] thr;
    goal = polls_sent + RANDOM_POLLS;
    since_cfg = 0;
    while (polls_sent < goal) begin
      if (since_cfg > 50) begin
        case ($urandom_range(0, 4))
          0:       thr = '0;
          1:       thr = THR_MAX;
          2:       thr = THR_W'(1);
          3:       thr = THR_RESET;
          default: thr = THR_W'($urandom_range(0, THR_MAX));
        endcase
        write_config($urandom_range(0, 5) != 0, 1'($urandom), 1'($urandom), 1'($urandom), thr);
        since_cfg = 0;
      end
      if ($urandom_range(0, 6) == 0) begin
        send_poll(noise_poll());
        since_cfg++;
      end else begin
        sent_before = polls_sent;
        send_touch();
        since_cfg += polls_sent - sent_before;
      end
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // items back to back, so the block fills and stalls its input.
  task automatic test_backpressure();
    write_config(1'b1, 1'b0, 1'b0, 1'b0, THR_RESET);
    use_gaps = 1'b0;
    hold_req = 80;
    for (int i = 0; i < 6; i++) send_touch();
    use_gaps = 1'b1;
  endtask

  // Sender pauses mid-touch until every result is back.
  task automatic test_pause();
    send_poll(press_poll(30, 40, 1));
    send_poll(press_poll(35, 45, 1));
    wait_drain();
    send_poll(press_poll(330, 60, MAX_FINGERS));
    wait_drain();
    send_poll(release_poll(REL_NO_FRAME));
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.frame_ok = 1'b0;
    in_ch.status_byte = '0;
    in_ch.x_high = '0;
    in_ch.x_low = '0;
    in_ch.y_high = '0;
    in_ch.y_low = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    cfg_enabled = 1'b0;
    cfg_swap = 1'b0;
    cfg_mirror_x = 1'b0;
    cfg_mirror_y = 1'b0;
    cfg_threshold = THR_RESET;
    touch_on = 1'b0;
    start_x = 0;
    start_y = 0;
    last_x = 0;
    last_y = 0;
    err_count = 0;
    polls_sent = 0;
    cfg_writes = 0;
    n_results = 0;
    n_taps = 0;
    n_swipes = 0;
    n_idle = 0;
    burst_left = 0;
    use_gaps = 1'b1;
    hold_req = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    test_pause();

    wait_drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d polls and %0d register writes; checked %0d results.",
             polls_sent, cfg_writes, n_results);
    $display("Results held %0d taps, %0d swipes and %0d polls with no gesture.",
             n_taps, n_swipes, n_idle);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_if.sv
rtl/touch_tap_swipe_classifier_top.sv
verif/tb.sv
